>>> design/osc_pkg.sv
package osc_pkg;

   // class set and datapath lanes
   localparam int CLASS_ROWS  = 4;
   localparam int NUM_CLASSES = 4;
   localparam int LANES       = 14;
   localparam int NSTAGE      = 16;
   localparam int GE_DEPTH    = 10;
   localparam int DIV_STAGES  = 4;

   // class codes
   localparam logic [2:0] CODE_UNKNOWN = 3'd0;
   localparam logic [2:0] CODE_PED     = 3'd1;
   localparam logic [2:0] CODE_CYC     = 3'd2;
   localparam logic [2:0] CODE_CAR     = 3'd3;
   localparam logic [2:0] CODE_TRUCK   = 3'd4;

   // lane source select
   localparam logic [1:0] SRC_LEN = 2'd0;
   localparam logic [1:0] SRC_WID = 2'd1;
   localparam logic [1:0] SRC_HGT = 2'd2;

   localparam logic [15:0] GROUND_OFFSET_RST = 16'd7475;
   localparam logic [16:0] LOG2E_Q16         = 17'd94548;
   localparam logic [16:0] ONE_Q16           = 17'd65536;

   // per lane: source, sigmoid (1) or gaussian (0), center, k or alpha
   localparam logic [1:0] LANE_SRC [LANES] = '{
      SRC_LEN, SRC_LEN, SRC_WID, SRC_HGT,
      SRC_LEN, SRC_WID, SRC_HGT,
      SRC_LEN, SRC_WID, SRC_HGT,
      SRC_LEN, SRC_LEN, SRC_WID, SRC_HGT};
   localparam logic LANE_SIG [LANES] = '{
      1'b1, 1'b1, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0,
      1'b1, 1'b1, 1'b0, 1'b0};
   localparam int LANE_CTR [LANES] = '{
      3072, 5939, 1946, 1536,
      1843, 512, 1536,
      819, 410, 1536,
      6656, 15360, 2560, 2867};
   localparam int LANE_COEF [LANES] = '{
      137626, 235930, 204800, 364089,
      131072, 819200, 364089,
      364089, 819200, 364089,
      104858, 65536, 364089, 91022};

   // per class in visiting order car, cyclist, pedestrian, truck
   localparam logic [2:0] CLASS_CODE [CLASS_ROWS] = '{CODE_CAR, CODE_CYC, CODE_PED, CODE_TRUCK};
   localparam logic CLASS_BAND [CLASS_ROWS] = '{1'b1, 1'b0, 1'b0, 1'b1};
   localparam int CLASS_L_LANE [CLASS_ROWS] = '{0, 4, 7, 10};
   localparam int CLASS_W_LANE [CLASS_ROWS] = '{2, 5, 8, 12};
   localparam int CLASS_Z_LANE [CLASS_ROWS] = '{3, 6, 9, 13};

   // 2^(-i/16) in Q16
   localparam logic [16:0] POW2 [17] = '{
      17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
      17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
      17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768};

   typedef struct packed {
      logic [17:0] rem;
      logic [15:0] q;
   } div_type;

   // four restoring steps of e*2^16 / (2^16 + e)
   function automatic div_type div_step4(input div_type din, input logic [16:0] e);
      logic [17:0] d;
      logic [18:0] r2;
      div_type     o;
      d = 18'({1'b0, e}) + 18'(ONE_Q16);
      o = din;
      for (int k = 0; k < 4; k++) begin
         r2 = {o.rem, 1'b0};
         if (r2 >= {1'b0, d}) begin
            o.rem = 18'(r2 - {1'b0, d});
            o.q   = {o.q[14:0], 1'b1};
         end else begin
            o.rem = r2[17:0];
            o.q   = {o.q[14:0], 1'b0};
         end
      end
      return o;
   endfunction

endpackage

>>> design/osc_req_if.sv
interface osc_req_if;
   logic               valid;
   logic               ready;
   logic        [15:0] extent_a;
   logic        [15:0] extent_b;
   logic signed [15:0] base_level;
   logic        [15:0] vertical_extent;

   modport source (output valid, extent_a, extent_b, base_level, vertical_extent,
                   input ready);
   modport sink (input valid, extent_a, extent_b, base_level, vertical_extent,
                 output ready);
endinterface

>>> design/osc_rsp_if.sv
interface osc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  class_code;
   logic [15:0] confidence;

   modport source (output valid, class_code, confidence, input ready);
   modport sink (input valid, class_code, confidence, output ready);
endinterface

>>> design/object_size_classifier_top.sv
// Throughput: one box per cycle while rsp does not stall; the 16-stage
// scoring pipeline (exp lanes, a 4-stage sigmoid divider, score multiplies,
// argmax) advances in lockstep.
// A one-beat skid buffer keeps req ready registered while rsp stalls.
// Reset (synchronous, active high) empties the pipeline and skid buffer and
// loads ground_offset with 7475 (7.3 m).
module object_size_classifier_top (
   input  logic               clock,
   input  logic               reset,
   osc_req_if.sink            req_bus,
   osc_rsp_if.source          rsp_bus,
   input  logic               csr_wr_en,
   input  logic signed [15:0] csr_wr_data
);

   localparam int L = osc_pkg::LANES;
   localparam int C = osc_pkg::CLASS_ROWS;

   logic en;
   logic [osc_pkg::NSTAGE-1:0] vld_ff;

   // config register
   logic signed [15:0] ground_offset_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ground_offset_ff <= osc_pkg::GROUND_OFFSET_RST;
      end else if (csr_wr_en) begin
         ground_offset_ff <= csr_wr_data;
      end
   end

   // skid buffer on the request side
   logic               skid_v_ff;
   logic        [15:0] skid_a_ff, skid_b_ff, skid_ve_ff;
   logic signed [15:0] skid_base_ff;
   logic               in_v;
   logic        [15:0] in_a, in_b, in_ve;
   logic signed [15:0] in_base;

   assign en            = !vld_ff[osc_pkg::NSTAGE-1] | rsp_bus.ready;
   assign req_bus.ready = !skid_v_ff;
   assign in_v    = skid_v_ff | req_bus.valid;
   assign in_a    = skid_v_ff ? skid_a_ff : req_bus.extent_a;
   assign in_b    = skid_v_ff ? skid_b_ff : req_bus.extent_b;
   assign in_ve   = skid_v_ff ? skid_ve_ff : req_bus.vertical_extent;
   assign in_base = skid_v_ff ? skid_base_ff : req_bus.base_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else if (en) begin
         skid_v_ff <= 1'b0;
      end else if (req_bus.valid && !skid_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && !skid_v_ff) begin
         skid_a_ff    <= req_bus.extent_a;
         skid_b_ff    <= req_bus.extent_b;
         skid_ve_ff   <= req_bus.vertical_extent;
         skid_base_ff <= req_bus.base_level;
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[osc_pkg::NSTAGE-2:0], in_v};
      end
   end

   // stage 1: length, width, height
   logic        [15:0] len_ff, wid_ff, len_in, wid_in;
   logic signed [17:0] hgt_ff, hgt_in;
   always_comb begin
      len_in = (in_a > in_b) ? in_a : in_b;
      wid_in = (in_a > in_b) ? in_b : in_a;
      hgt_in = 18'(in_base) + $signed({3'b000, in_ve[15:1]}) + 18'(ground_offset_ff);
   end
   always_ff @(posedge clock) begin
      if (en) begin
         len_ff <= len_in;
         wid_ff <= wid_in;
         hgt_ff <= hgt_in;
      end
   end

   // stage 2: |x - center| and sign per lane
   logic [16:0] ad_ff [L];
   logic [16:0] ad_in [L];
   logic [L-1:0] ge_ff [osc_pkg::GE_DEPTH];
   logic [L-1:0] ge_in;
   always_comb begin
      logic signed [17:0] x;
      logic signed [17:0] d;
      for (int l = 0; l < L; l++) begin
         case (osc_pkg::LANE_SRC[l])
            osc_pkg::SRC_LEN: x = $signed({2'b00, len_ff});
            osc_pkg::SRC_WID: x = $signed({2'b00, wid_ff});
            default:          x = hgt_ff;
         endcase
         d = x - $signed(18'(osc_pkg::LANE_CTR[l]));
         ge_in[l] = !d[17];
         ad_in[l] = d[17] ? 17'(-d) : d[16:0];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         ad_ff    <= ad_in;
         ge_ff[0] <= ge_in;
         for (int s = 1; s < osc_pkg::GE_DEPTH; s++) begin
            ge_ff[s] <= ge_ff[s-1];
         end
      end
   end

   // stage 3: square (gaussian) or scale by alpha (sigmoid)
   logic [24:0] m_ff [L];
   logic [24:0] m_in [L];
   logic [L-1:0] big_ff, big_in;
   always_comb begin
      logic [33:0] sq;
      logic [36:0] y;
      for (int l = 0; l < L; l++) begin
         sq = 34'(ad_ff[l]) * 34'(ad_ff[l]);
         y  = 37'(ad_ff[l]) * 37'(osc_pkg::LANE_COEF[l]);
         if (osc_pkg::LANE_SIG[l]) begin
            m_in[l]   = y[34:10];
            big_in[l] = 1'b0;
         end else begin
            // a clamped square always drives exp to zero
            m_in[l]   = sq[24:0];
            big_in[l] = |sq[33:25];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         m_ff   <= m_in;
         big_ff <= big_in;
      end
   end

   // stage 4: exp argument t in Q16
   logic [24:0] t_ff [L];
   logic [24:0] t_in [L];
   logic [L-1:0] tz_ff;
   always_comb begin
      logic [44:0] pr;
      for (int l = 0; l < L; l++) begin
         pr = 45'(m_ff[l]) * 45'(osc_pkg::LANE_COEF[l]);
         t_in[l] = osc_pkg::LANE_SIG[l] ? m_ff[l] : pr[44:20];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         t_ff  <= t_in;
         tz_ff <= big_ff;
      end
   end

   // stage 5: t * log2(e), split into integer and fraction
   logic [15:0] f_ff [L];
   logic [15:0] f_in [L];
   logic [4:0]  n5_ff [L];
   logic [4:0]  n5_in [L];
   logic [L-1:0] z5_ff, z5_in;
   always_comb begin
      logic [41:0] u;
      for (int l = 0; l < L; l++) begin
         u = 42'(t_ff[l]) * 42'(osc_pkg::LOG2E_Q16);
         f_in[l]  = u[31:16];
         n5_in[l] = u[36:32];
         z5_in[l] = tz_ff[l] | (u[41:32] >= 10'd17);
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         f_ff  <= f_in;
         n5_ff <= n5_in;
         z5_ff <= z5_in;
      end
   end

   // stage 6: table lookup and linear interpolation
   logic [16:0] v6_ff [L];
   logic [16:0] v6_in [L];
   logic [4:0]  n6_ff [L];
   logic [L-1:0] z6_ff;
   always_comb begin
      logic [4:0]  i;
      logic [16:0] pa, pb, dl;
      logic [28:0] corr;
      for (int l = 0; l < L; l++) begin
         i    = {1'b0, f_ff[l][15:12]};
         pa   = osc_pkg::POW2[i];
         pb   = osc_pkg::POW2[i + 5'd1];
         dl   = pa - pb;
         corr = 29'(dl) * 29'(f_ff[l][11:0]);
         v6_in[l] = pa - corr[28:12];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         v6_ff <= v6_in;
         n6_ff <= n5_ff;
         z6_ff <= z5_ff;
      end
   end

   // stage 7: exponent shift
   logic [16:0] e_ff [L];
   logic [16:0] e_in [L];
   always_comb begin
      for (int l = 0; l < L; l++) begin
         e_in[l] = z6_ff[l] ? 17'd0 : (v6_ff[l] >> n6_ff[l]);
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= e_in;
      end
   end

   // stages 8..11: q = e*2^16 / (2^16 + e), four quotient bits per stage
   osc_pkg::div_type dv_ff [osc_pkg::DIV_STAGES][L];
   osc_pkg::div_type dv_in [osc_pkg::DIV_STAGES][L];
   logic [16:0]      ed_ff [osc_pkg::DIV_STAGES][L];
   always_comb begin
      osc_pkg::div_type st;
      for (int l = 0; l < L; l++) begin
         st.rem = {1'b0, e_ff[l]};
         st.q   = '0;
         dv_in[0][l] = osc_pkg::div_step4(st, e_ff[l]);
         for (int s = 1; s < osc_pkg::DIV_STAGES; s++) begin
            dv_in[s][l] = osc_pkg::div_step4(dv_ff[s-1][l], ed_ff[s-1][l]);
         end
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff    <= dv_in;
         ed_ff[0] <= e_ff;
         for (int s = 1; s < osc_pkg::DIV_STAGES; s++) begin
            ed_ff[s] <= ed_ff[s-1];
         end
      end
   end

   // stage 12: lane term
   logic [16:0] p_ff [L];
   logic [16:0] p_in [L];
   always_comb begin
      logic [16:0] q;
      for (int l = 0; l < L; l++) begin
         q = {1'b0, dv_ff[osc_pkg::DIV_STAGES-1][l].q};
         if (osc_pkg::LANE_SIG[l]) begin
            p_in[l] = ge_ff[osc_pkg::GE_DEPTH-1][l] ? (osc_pkg::ONE_Q16 - q) : q;
         end else begin
            p_in[l] = ed_ff[osc_pkg::DIV_STAGES-1][l];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   // stage 13: length term (band-pass or gaussian)
   logic [16:0] pl_ff [C];
   logic [16:0] pl_in [C];
   logic [16:0] pw_ff [C];
   logic [16:0] pz_ff [C];
   always_comb begin
      logic [33:0] bp;
      for (int c = 0; c < C; c++) begin
         bp = 34'(p_ff[osc_pkg::CLASS_L_LANE[c]])
            * 34'(osc_pkg::ONE_Q16 - p_ff[osc_pkg::CLASS_L_LANE[c] + 1]);
         pl_in[c] = osc_pkg::CLASS_BAND[c] ? bp[32:16] : p_ff[osc_pkg::CLASS_L_LANE[c]];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff <= pl_in;
         for (int c = 0; c < C; c++) begin
            pw_ff[c] <= p_ff[osc_pkg::CLASS_W_LANE[c]];
            pz_ff[c] <= p_ff[osc_pkg::CLASS_Z_LANE[c]];
         end
      end
   end

   // stage 14: length * width
   logic [16:0] lw_ff [C];
   logic [16:0] lw_in [C];
   logic [16:0] pz2_ff [C];
   always_comb begin
      logic [33:0] pr;
      for (int c = 0; c < C; c++) begin
         pr = 34'(pl_ff[c]) * 34'(pw_ff[c]);
         lw_in[c] = pr[32:16];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         lw_ff  <= lw_in;
         pz2_ff <= pz_ff;
      end
   end

   // stage 15: times height
   logic [16:0] s_ff [C];
   logic [16:0] s_in [C];
   always_comb begin
      logic [33:0] pr;
      for (int c = 0; c < C; c++) begin
         pr = 34'(lw_ff[c]) * 34'(pz2_ff[c]);
         s_in[c] = pr[32:16];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= s_in;
      end
   end

   // stage 16: strict argmax in visiting order, saturate
   logic [2:0]  class_ff, class_in;
   logic [15:0] conf_ff, conf_in;
   always_comb begin
      logic [16:0] best;
      best     = '0;
      class_in = osc_pkg::CODE_UNKNOWN;
      for (int c = 0; c < C; c++) begin
         if (c < osc_pkg::NUM_CLASSES && s_ff[c] > best) begin
            best     = s_ff[c];
            class_in = osc_pkg::CLASS_CODE[c];
         end
      end
      conf_in = best[16] ? 16'hFFFF : best[15:0];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         class_ff <= class_in;
         conf_ff  <= conf_in;
      end
   end

   assign rsp_bus.valid      = vld_ff[osc_pkg::NSTAGE-1];
   assign rsp_bus.class_code = class_ff;
   assign rsp_bus.confidence = conf_ff;

endmodule
